// ===== src/dhte_pkg.sv =====
`timescale 1ns / 1ps
package dhte_pkg;
   localparam int SlotDepth = 1024;
   localparam int IdxBits = $clog2(SlotDepth);
   localparam int LenBits = IdxBits + 1;
   localparam int KeyBits = 32;
   localparam int ValueBits = 32;
   localparam int PrimeBits = 10;
   localparam int HashBits = 32;
   localparam int AddrBits = 3;

   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_LOOKUP = 2'd1;
   localparam logic [1:0] OP_DELETE = 2'd2;
   localparam logic [1:0] OP_CLEAR = 2'd3;

   localparam logic [1:0] ST_DONE = 2'd0;
   localparam logic [1:0] ST_REPLACED = 2'd1;
   localparam logic [1:0] ST_MISSING = 2'd2;
   localparam logic [1:0] ST_FULL = 2'd3;

   localparam logic [AddrBits-1:0] REG_SLOTS = 3'd0;
   localparam logic [AddrBits-1:0] REG_PRIME = 3'd4;

   typedef struct packed {
      logic [1:0] operation;
      logic [KeyBits-1:0] key;
      logic [HashBits-1:0] key_hash;
      logic [ValueBits-1:0] value;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic found;
      logic [ValueBits-1:0] value_out;
      logic [LenBits-1:0] entries_now;
   } rsp_type;

   typedef struct packed {
      logic start;
      logic [HashBits-1:0] dividend;
      logic [HashBits-1:0] divisor;
   } div_cmd_type;

   typedef struct packed {
      logic done;
      logic [HashBits-1:0] remainder;
   } div_rsp_type;
endpackage

// ===== src/dhte_divider.sv =====
`timescale 1ns / 1ps
module dhte_divider (
   input logic clock,
   input logic reset,
   input dhte_pkg::div_cmd_type cmd,
   output dhte_pkg::div_rsp_type rsp
);
   localparam int W = dhte_pkg::HashBits;
   logic [W-1:0] quo_ff, quo_in;
   logic [W:0] rem_ff, rem_in;
   logic [W-1:0] div_ff, div_in;
   logic [$clog2(W+1)-1:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in, done_ff, done_in;
   logic [W:0] shifted, diff;

   always_comb begin
      quo_in = quo_ff;
      rem_in = rem_ff;
      div_in = div_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      shifted = {rem_ff[W-1:0], quo_ff[W-1]};
      diff = shifted - {1'b0, div_ff};
      if (cmd.start) begin
         quo_in = cmd.dividend;
         rem_in = '0;
         div_in = cmd.divisor;
         cnt_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[W-2:0], 1'b0};
         rem_in = diff[W] ? shifted : diff;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == ($clog2(W+1))'(W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign rsp.done = done_ff;
   assign rsp.remainder = rem_ff[W-1:0];
endmodule

// ===== src/dhte_slot_store.sv =====
`timescale 1ns / 1ps
module dhte_slot_store (
   input logic clock,
   input logic [dhte_pkg::IdxBits-1:0] rd_addr,
   output logic rd_used,
   output logic [dhte_pkg::KeyBits-1:0] rd_key,
   output logic [dhte_pkg::ValueBits-1:0] rd_value,
   input logic wr_en,
   input logic wr_key_en,
   input logic wr_used_en,
   input logic wr_used,
   input logic [dhte_pkg::IdxBits-1:0] wr_addr,
   input logic [dhte_pkg::KeyBits-1:0] wr_key,
   input logic [dhte_pkg::ValueBits-1:0] wr_value
);
   logic used_mem [dhte_pkg::SlotDepth];
   logic [dhte_pkg::KeyBits-1:0] key_mem [dhte_pkg::SlotDepth];
   logic [dhte_pkg::ValueBits-1:0] value_mem [dhte_pkg::SlotDepth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         value_mem[wr_addr] <= wr_value;
         if (wr_key_en) begin
            key_mem[wr_addr] <= wr_key;
         end
      end
      if (wr_used_en) begin
         used_mem[wr_addr] <= wr_used;
      end
      rd_used <= used_mem[rd_addr];
      rd_key <= key_mem[rd_addr];
      rd_value <= value_mem[rd_addr];
   end
endmodule

// ===== src/double_hash_table_engine.sv =====
`timescale 1ns / 1ps
// Open-addressing key/value table with double hashing.
// Requests arrive on req_ as one transaction each, carrying an operation, a key, the key hash
// and a value. Each request yields exactly one response transaction on rsp_.
// The table length and step prime are written through the APB port; the user must write
// them only while the block is idle, which the block itself does not enforce. A request
// other than Clear first takes three remainders (h mod P, the step mod L and h mod L) on a
// shared 32-step restoring divider, then probes slots in turn through the registered key,
// value and occupancy memory, reading and then checking each one, at most L probes.
// Clear walks all 1024 slots one per cycle before it responds.
// One request is handled at a time; req_ready is high only while the block is idle, which
// is from the same cycle in which rsp_valid rises.
// While a response waits in the output register because rsp_ready is low, the next request
// is accepted and processed, and it holds before its own result is written until the
// waiting response is taken.
// Reset restores L = 11, P = 7, zeroes the entry count and then clears the occupancy bits
// of all 1024 slots, during which req_ready stays low.
module double_hash_table_engine (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_ready,
   input dhte_pkg::req_type req_data,
   output logic rsp_valid,
   input logic rsp_ready,
   output dhte_pkg::rsp_type rsp_data,
   input logic psel,
   input logic penable,
   input logic pwrite,
   input logic [dhte_pkg::AddrBits-1:0] paddr,
   input logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic pready
);
   localparam int IB = dhte_pkg::IdxBits;
   localparam int LB = dhte_pkg::LenBits;
   localparam int HB = dhte_pkg::HashBits;

   typedef enum logic [3:0] {
      S_INIT, S_IDLE, S_CLEAR, S_MODP, S_WAITP, S_MODL1, S_WAITL1, S_MODL2, S_WAITL2,
      S_FIRST, S_READ, S_CHECK, S_FINISH, S_RESP
   } state_type;

   state_type state_ff, state_in;
   logic [LB-1:0] slots_ff, slots_in;
   logic [dhte_pkg::PrimeBits-1:0] prime_ff, prime_in;
   logic [IB-1:0] clr_ff, clr_in;
   logic [LB-1:0] count_ff, count_in;
   dhte_pkg::req_type req_ff, req_in;
   dhte_pkg::rsp_type rsp_ff, rsp_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [LB-1:0] len_ff, len_in;
   logic [HB-1:0] tmp_ff, tmp_in;
   logic [IB-1:0] step_ff, step_in;
   logic [IB-1:0] first_ff, first_in;
   logic [IB-1:0] idx_ff, idx_in;
   logic [LB-1:0] n_ff, n_in;
   logic hit_ff, hit_in, empty_ff, empty_in;

   dhte_pkg::div_cmd_type div_cmd;
   dhte_pkg::div_rsp_type div_rsp;
   logic rd_used;
   logic [dhte_pkg::KeyBits-1:0] rd_key;
   logic [dhte_pkg::ValueBits-1:0] rd_value;
   logic wr_en, wr_key_en, wr_used_en, wr_used;
   logic [IB-1:0] wr_addr;
   logic cfg_wr;
   logic [LB-1:0] eff_len;
   logic [HB-1:0] eff_prime;
   logic [LB:0] idx_sum;
   logic [LB-1:0] idx_next;

   dhte_divider u_div (.clock(clock), .reset(reset), .cmd(div_cmd), .rsp(div_rsp));

   dhte_slot_store u_store (
      .clock(clock), .rd_addr(idx_ff), .rd_used(rd_used), .rd_key(rd_key),
      .rd_value(rd_value), .wr_en(wr_en), .wr_key_en(wr_key_en),
      .wr_used_en(wr_used_en), .wr_used(wr_used), .wr_addr(wr_addr),
      .wr_key(req_ff.key), .wr_value(req_ff.value)
   );

   assign cfg_wr = psel & penable & pwrite;
   assign pready = 1'b1;
   always_comb begin
      prdata = '0;
      case (paddr)
         dhte_pkg::REG_SLOTS: prdata = 32'(slots_ff);
         dhte_pkg::REG_PRIME: prdata = 32'(prime_ff);
         default: prdata = '0;
      endcase
   end

   always_comb begin
      if (slots_ff == '0) eff_len = LB'(1);
      else if (slots_ff > LB'(dhte_pkg::SlotDepth)) eff_len = LB'(dhte_pkg::SlotDepth);
      else eff_len = slots_ff;
      eff_prime = (prime_ff == '0) ? HB'(1) : HB'(prime_ff);
   end

   assign idx_sum = {2'b0, idx_ff} + {2'b0, step_ff};
   assign idx_next = (idx_sum >= {1'b0, len_ff}) ? LB'(idx_sum - {1'b0, len_ff})
                                                : LB'(idx_sum);

   always_comb begin
      state_in = state_ff;
      slots_in = slots_ff;
      prime_in = prime_ff;
      clr_in = clr_ff;
      count_in = count_ff;
      req_in = req_ff;
      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      len_in = len_ff;
      tmp_in = tmp_ff;
      step_in = step_ff;
      first_in = first_ff;
      idx_in = idx_ff;
      n_in = n_ff;
      hit_in = hit_ff;
      empty_in = empty_ff;
      div_cmd = '0;
      wr_en = 1'b0;
      wr_key_en = 1'b0;
      wr_used_en = 1'b0;
      wr_used = 1'b0;
      wr_addr = idx_ff;

      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      if (cfg_wr) begin
         case (paddr)
            dhte_pkg::REG_SLOTS: slots_in = pwdata[LB-1:0];
            dhte_pkg::REG_PRIME: prime_in = pwdata[dhte_pkg::PrimeBits-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         S_INIT, S_CLEAR: begin
            wr_addr = clr_ff;
            wr_used_en = 1'b1;
            wr_used = 1'b0;
            clr_in = clr_ff + IB'(1);
            if (clr_ff == IB'(dhte_pkg::SlotDepth - 1)) begin
               state_in = (state_ff == S_INIT) ? S_IDLE : S_FINISH;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               req_in = req_data;
               len_in = eff_len;
               hit_in = 1'b0;
               empty_in = 1'b0;
               n_in = '0;
               clr_in = '0;
               state_in = (req_data.operation == dhte_pkg::OP_CLEAR) ? S_CLEAR : S_MODP;
            end
         end
         S_MODP: begin
            div_cmd.start = 1'b1;
            div_cmd.dividend = req_ff.key_hash;
            div_cmd.divisor = eff_prime;
            state_in = S_WAITP;
         end
         S_WAITP: begin
            if (div_rsp.done) begin
               tmp_in = eff_prime - div_rsp.remainder;
               state_in = S_MODL1;
            end
         end
         S_MODL1: begin
            div_cmd.start = 1'b1;
            div_cmd.dividend = tmp_ff;
            div_cmd.divisor = HB'(len_ff);
            state_in = S_WAITL1;
         end
         S_WAITL1: begin
            if (div_rsp.done) begin
               step_in = IB'(div_rsp.remainder);
               state_in = S_MODL2;
            end
         end
         S_MODL2: begin
            div_cmd.start = 1'b1;
            div_cmd.dividend = req_ff.key_hash;
            div_cmd.divisor = HB'(len_ff);
            state_in = S_WAITL2;
         end
         S_WAITL2: begin
            if (div_rsp.done) begin
               idx_in = IB'(div_rsp.remainder);
               state_in = S_FIRST;
            end
         end
         S_FIRST: begin
            first_in = IB'(idx_next);
            idx_in = IB'(idx_next);
            state_in = S_READ;
         end
         S_READ: begin
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if (n_ff != '0 && idx_ff == first_ff) begin
               state_in = S_FINISH;
            end else if (rd_used && rd_key == req_ff.key) begin
               hit_in = 1'b1;
               state_in = S_FINISH;
            end else if (!rd_used && req_ff.operation == dhte_pkg::OP_INSERT) begin
               empty_in = 1'b1;
               state_in = S_FINISH;
            end else if (n_ff + LB'(1) >= len_ff) begin
               state_in = S_FINISH;
            end else begin
               n_in = n_ff + LB'(1);
               idx_in = IB'(idx_next);
               state_in = S_READ;
            end
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in.status = dhte_pkg::ST_DONE;
               rsp_in.found = 1'b0;
               rsp_in.value_out = '0;
               if (req_ff.operation == dhte_pkg::OP_CLEAR) begin
                  count_in = '0;
               end else if (req_ff.operation == dhte_pkg::OP_INSERT) begin
                  if (hit_ff) begin
                     wr_en = 1'b1;
                     rsp_in.status = dhte_pkg::ST_REPLACED;
                     rsp_in.found = 1'b1;
                  end else if (empty_ff) begin
                     wr_en = 1'b1;
                     wr_key_en = 1'b1;
                     wr_used_en = 1'b1;
                     wr_used = 1'b1;
                     count_in = count_ff + LB'(1);
                  end else begin
                     rsp_in.status = dhte_pkg::ST_FULL;
                  end
               end else if (hit_ff) begin
                  rsp_in.found = 1'b1;
                  rsp_in.value_out = rd_value;
                  if (req_ff.operation == dhte_pkg::OP_DELETE) begin
                     wr_used_en = 1'b1;
                     wr_used = 1'b0;
                     if (count_ff != '0) count_in = count_ff - LB'(1);
                  end
               end else begin
                  rsp_in.status = dhte_pkg::ST_MISSING;
               end
               rsp_in.entries_now = count_in;
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
         slots_ff <= LB'(11);
         prime_ff <= dhte_pkg::PrimeBits'(7);
         clr_ff <= '0;
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         slots_ff <= slots_in;
         prime_ff <= prime_in;
         clr_ff <= clr_in;
         count_ff <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff <= req_in;
      rsp_ff <= rsp_in;
      len_ff <= len_in;
      tmp_ff <= tmp_in;
      step_ff <= step_in;
      first_ff <= first_in;
      idx_ff <= idx_in;
      n_ff <= n_in;
      hit_ff <= hit_in;
      empty_ff <= empty_in;
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= LB'(dhte_pkg::SlotDepth))
      else $error("entry count exceeds slot depth");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |=> rsp_valid_ff && $stable(rsp_ff))
      else $error("response changed while stalled");
   a_found_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.found |-> rsp_ff.status == dhte_pkg::ST_DONE
         || rsp_ff.status == dhte_pkg::ST_REPLACED)
      else $error("found with miss status");
   a_probe_idx: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CHECK |-> {1'b0, idx_ff} < len_ff)
      else $error("probe index out of table");
endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
   localparam int HangLimit = 20000;
   localparam int SettleCycles = 20;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   dhte_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   dhte_pkg::rsp_type rsp_data;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [dhte_pkg::AddrBits-1:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;

   double_hash_table_engine uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always #2 clock = ~clock;

   // Shadow copy of the table.
   logic [dhte_pkg::LenBits-1:0] tbl_len_reg;
   logic [dhte_pkg::PrimeBits-1:0] tbl_prime_reg;
   logic shadow_used [dhte_pkg::SlotDepth];
   logic [dhte_pkg::KeyBits-1:0] shadow_key [dhte_pkg::SlotDepth];
   logic [dhte_pkg::ValueBits-1:0] shadow_value [dhte_pkg::SlotDepth];
   int unsigned shadow_count;

   dhte_pkg::rsp_type pending_rsp [$];
   dhte_pkg::rsp_type want;
   int errors = 0;
   bit idle_on = 1'b1;
   int hold_left = 0;
   int stall_left = 0;
   int quiet_cycles = 0;

   logic [dhte_pkg::KeyBits-1:0] key_pool [16];
   logic [dhte_pkg::HashBits-1:0] hash_pool [16];

   function automatic dhte_pkg::rsp_type table_apply(dhte_pkg::req_type r);
      dhte_pkg::rsp_type res;
      int unsigned len, p, h, step, first, idx, n;
      bit hit, empty;
      res = '0;
      hit = 0;
      empty = 0;
      if (r.operation == dhte_pkg::OP_CLEAR) begin
         for (int i = 0; i < dhte_pkg::SlotDepth; i++) shadow_used[i] = 1'b0;
         shadow_count = 0;
      end else begin
         len = 32'(tbl_len_reg);
         if (len == 0) len = 1;
         if (len > dhte_pkg::SlotDepth) len = dhte_pkg::SlotDepth;
         p = (tbl_prime_reg == '0) ? 1 : 32'(tbl_prime_reg);
         h = r.key_hash;
         step = (p - (h % p)) % len;
         first = ((h % len) + step) % len;
         idx = first;
         for (n = 0; n < len; n++) begin
            if (n > 0 && idx == first) break;
            if (shadow_used[idx]) begin
               if (shadow_key[idx] == r.key) begin
                  hit = 1;
                  break;
               end
            end else if (r.operation == dhte_pkg::OP_INSERT) begin
               empty = 1;
               break;
            end
            idx = (idx + step) % len;
         end
         if (r.operation == dhte_pkg::OP_INSERT) begin
            if (hit) begin
               shadow_value[idx] = r.value;
               res.status = dhte_pkg::ST_REPLACED;
               res.found = 1'b1;
            end else if (empty) begin
               shadow_used[idx] = 1'b1;
               shadow_key[idx] = r.key;
               shadow_value[idx] = r.value;
               shadow_count++;
               res.status = dhte_pkg::ST_DONE;
            end else begin
               res.status = dhte_pkg::ST_FULL;
            end
         end else if (hit) begin
            res.status = dhte_pkg::ST_DONE;
            res.found = 1'b1;
            res.value_out = shadow_value[idx];
            if (r.operation == dhte_pkg::OP_DELETE) begin
               shadow_used[idx] = 1'b0;
               if (shadow_count > 0) shadow_count--;
            end
         end else begin
            res.status = dhte_pkg::ST_MISSING;
         end
      end
      res.entries_now = shadow_count[dhte_pkg::LenBits-1:0];
      return res;
   endfunction

   task automatic report_error(string what, logic [63:0] got, logic [63:0] exp);
      $display("%0t mismatch on %s: got %0h, expected %0h", $time, what, got, exp);
      errors++;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_rsp.size() == 0) begin
            report_error("unexpected transaction", 64'(rsp_data), 64'd0);
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_data.status !== want.status)
               report_error("status", 64'(rsp_data.status), 64'(want.status));
            if (rsp_data.found !== want.found)
               report_error("found", 64'(rsp_data.found), 64'(want.found));
            if (rsp_data.value_out !== want.value_out)
               report_error("value_out", 64'(rsp_data.value_out), 64'(want.value_out));
            if (rsp_data.entries_now !== want.entries_now)
               report_error("entries_now", 64'(rsp_data.entries_now),
                            64'(want.entries_now));
         end
      end
   end

   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
         rsp_ready <= 1'b0;
         stall_left <= $urandom_range(0, 9);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || (psel && penable))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= HangLimit) begin
         $display("tb_top: errors");
         $finish;
      end
   end

   task automatic send_item(logic [1:0] op, logic [31:0] k, logic [31:0] h, logic [31:0] v);
      dhte_pkg::req_type r;
      r.operation = op;
      r.key = k;
      r.key_hash = h;
      r.value = v;
      @(negedge clock);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 10)) @(negedge clock);
      end
      req_valid = 1'b1;
      req_data = r;
      do @(posedge clock); while (!req_ready);
      pending_rsp.push_back(table_apply(r));
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic csr_write(logic [dhte_pkg::AddrBits-1:0] addr, logic [31:0] data);
      @(negedge clock);
      psel = 1'b1;
      penable = 1'b0;
      pwrite = 1'b1;
      paddr = addr;
      pwdata = data;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      if (addr == dhte_pkg::REG_SLOTS) tbl_len_reg = data[dhte_pkg::LenBits-1:0];
      else tbl_prime_reg = data[dhte_pkg::PrimeBits-1:0];
      @(negedge clock);
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
   endtask

   task automatic set_geometry(int len, int prime);
      drain();
      csr_write(dhte_pkg::REG_SLOTS, len);
      csr_write(dhte_pkg::REG_PRIME, prime);
   endtask

   task automatic refill_pools();
      for (int i = 0; i < 16; i++) begin
         key_pool[i] = $urandom;
         hash_pool[i] = $urandom;
      end
   endtask

   task automatic send_random_item();
      logic [1:0] op;
      logic [31:0] k, h;
      int pick, sel;
      pick = $urandom_range(0, 99);
      if (pick < 45) op = dhte_pkg::OP_INSERT;
      else if (pick < 70) op = dhte_pkg::OP_LOOKUP;
      else if (pick < 97) op = dhte_pkg::OP_DELETE;
      else op = dhte_pkg::OP_CLEAR;
      sel = $urandom_range(0, 15);
      k = key_pool[sel];
      h = hash_pool[sel];
      if ($urandom_range(0, 9) == 0) k = $urandom;
      if ($urandom_range(0, 9) == 0) h = $urandom;
      send_item(op, k, h, $urandom);
   endtask

   task automatic test_basic_ops();
      send_item(dhte_pkg::OP_INSERT, 32'h0, 32'h0, 32'h0);
      send_item(dhte_pkg::OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_item(dhte_pkg::OP_LOOKUP, 32'h0, 32'h0, 32'h0);
      send_item(dhte_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0);
      send_item(dhte_pkg::OP_INSERT, 32'h0, 32'h0, 32'hA5A5_5A5A);
      send_item(dhte_pkg::OP_LOOKUP, 32'h0, 32'h0, 32'h0);
      send_item(dhte_pkg::OP_LOOKUP, 32'h1234_5678, 32'h5, 32'h0);
      send_item(dhte_pkg::OP_DELETE, 32'h1234_5678, 32'h5, 32'h0);
      send_item(dhte_pkg::OP_DELETE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0);
      send_item(dhte_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0);
      // Two keys on one hash, then a hole that lets a second copy in.
      send_item(dhte_pkg::OP_INSERT, 32'h11, 32'h77, 32'h1);
      send_item(dhte_pkg::OP_INSERT, 32'h22, 32'h77, 32'h2);
      send_item(dhte_pkg::OP_DELETE, 32'h11, 32'h77, 32'h0);
      send_item(dhte_pkg::OP_INSERT, 32'h22, 32'h77, 32'h3);
      send_item(dhte_pkg::OP_LOOKUP, 32'h22, 32'h77, 32'h0);
      send_item(dhte_pkg::OP_DELETE, 32'h22, 32'h77, 32'h0);
      send_item(dhte_pkg::OP_LOOKUP, 32'h22, 32'h77, 32'h0);
      send_item(dhte_pkg::OP_CLEAR, 32'h0, 32'h0, 32'h0);
   endtask

   task automatic test_full_table();
      for (int i = 0; i < 12; i++)
         send_item(dhte_pkg::OP_INSERT, 32'h100 + i, i * 3, $urandom);
      send_item(dhte_pkg::OP_INSERT, 32'h105, 32'd15, 32'hBEEF);
      send_item(dhte_pkg::OP_LOOKUP, 32'h105, 32'd15, 32'h0);
      send_item(dhte_pkg::OP_CLEAR, 32'h0, 32'h0, 32'h0);
   endtask

   task automatic test_odd_lengths();
      set_geometry(2, 1);
      for (int i = 0; i < 8; i++) send_random_item();
      set_geometry(0, 0);
      for (int i = 0; i < 8; i++) send_random_item();
      set_geometry(1024, 1023);
      for (int i = 0; i < 12; i++) send_random_item();
      set_geometry(2047, 0);
      for (int i = 0; i < 8; i++) send_random_item();
      send_item(dhte_pkg::OP_CLEAR, 32'h0, 32'h0, 32'h0);
   endtask

   task automatic test_shrink();
      set_geometry(31, 29);
      for (int i = 0; i < 20; i++)
         send_item(dhte_pkg::OP_INSERT, key_pool[i % 16] + i, $urandom, i);
      set_geometry(13, 11);
      for (int i = 0; i < 20; i++) send_random_item();
      set_geometry(31, 29);
      for (int i = 0; i < 10; i++) send_random_item();
      send_item(dhte_pkg::OP_CLEAR, 32'h0, 32'h0, 32'h0);
   endtask

   task automatic test_backpressure();
      @(negedge clock);
      hold_left = 2500;
      for (int i = 0; i < 6; i++) send_random_item();
      drain();
      for (int i = 0; i < 6; i++) send_random_item();
   endtask

   task automatic test_random_phases();
      int lens [7] = '{3, 5, 7, 11, 13, 17, 31};
      int primes [7] = '{2, 3, 5, 7, 11, 13, 29};
      int c;
      for (int ph = 0; ph < 6; ph++) begin
         c = $urandom_range(0, 6);
         set_geometry(lens[c], primes[c]);
         refill_pools();
         if (ph == 5) idle_on = 1'b0;
         for (int i = 0; i < 100; i++) send_random_item();
      end
   endtask

   initial begin
      refill_pools();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      tbl_len_reg = 11;
      tbl_prime_reg = 7;
      for (int i = 0; i < dhte_pkg::SlotDepth; i++) shadow_used[i] = 1'b0;
      shadow_count = 0;
      test_basic_ops();
      test_full_table();
      test_odd_lengths();
      test_shrink();
      test_backpressure();
      test_random_phases();
      drain();
      repeat (100) @(posedge clock);
      if (errors == 0)
         $display("tb_top: clean");
      else
         $display("tb_top: errors");
      $finish;
   end
endmodule

// ===== sim.f =====
src/dhte_pkg.sv
src/dhte_divider.sv
src/dhte_slot_store.sv
src/double_hash_table_engine.sv
tb/sv/tb_top.sv
